// ----- src/sclm_pkg.sv -----
package sclm_pkg;

    localparam int BYTE_W     = 8;
    localparam int WORD_CHARS = 8;
    localparam int WORD_W     = BYTE_W * WORD_CHARS;
    localparam int POS_W      = 4;
    localparam int COUNT_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int SLOT_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TERMINATOR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WORD0      = 3'd2;

    localparam logic [BYTE_W-1:0] TERM_RESET = 8'd13;
    localparam logic [BYTE_W-1:0] PRINT_LO   = 8'h20;
    localparam logic [BYTE_W-1:0] PRINT_HI   = 8'h7E;

    typedef struct packed {
        logic               push;
        logic               clear;
        logic [BYTE_W-1:0]  char_in;
    } t_line_ctl;

endpackage

// ----- src/sclm_line.sv -----
module sclm_line #(
    parameter int LINE_CAP = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sclm_pkg::t_line_ctl            i_ctl,
    output logic [sclm_pkg::WORD_W-1:0]    o_line,
    output logic [sclm_pkg::POS_W-1:0]     o_pos
);

    localparam int IDX_W = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;

    logic [sclm_pkg::BYTE_W-1:0] r_chars [LINE_CAP];
    logic [sclm_pkg::POS_W-1:0]  r_pos;
    logic [IDX_W-1:0]            w_idx;
    logic                        w_wrap;

    // a full line wraps, the new char lands in entry 0
    assign w_wrap = (r_pos >= sclm_pkg::POS_W'(LINE_CAP));
    assign w_idx  = w_wrap ? '0 : r_pos[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_ctl.clear) begin
            r_pos <= '0;
        end else if (i_ctl.push) begin
            r_pos <= sclm_pkg::POS_W'(w_idx) + sclm_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && !i_ctl.clear) begin
            r_chars[w_idx] <= i_ctl.char_in;
        end
    end

    genvar g;
    generate
        for (g = 0; g < sclm_pkg::WORD_CHARS; g++) begin : g_out
            if (g < LINE_CAP) begin : g_used
                assign o_line[g*sclm_pkg::BYTE_W +: sclm_pkg::BYTE_W] = r_chars[g];
            end else begin : g_pad
                assign o_line[g*sclm_pkg::BYTE_W +: sclm_pkg::BYTE_W] = '0;
            end
        end
    endgenerate

    assign o_pos = r_pos;

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= sclm_pkg::POS_W'(LINE_CAP))
        else $error("line position beyond capacity");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |=> r_pos == '0)
        else $error("line not emptied after terminator");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.push && !i_ctl.clear && !w_wrap) |=> r_pos == $past(r_pos) + 4'd1)
        else $error("line position did not advance");

endmodule

// ----- src/sclm_match.sv -----
module sclm_match (
    input  logic [sclm_pkg::WORD_W-1:0] i_word,
    input  logic [sclm_pkg::WORD_W-1:0] i_line,
    input  logic [sclm_pkg::POS_W-1:0]  i_len,
    output logic                        o_hit
);

    logic [sclm_pkg::WORD_CHARS-1:0] w_ok;

    // chars below len must agree, the word char at len must be the zero pad
    always_comb begin
        for (int i = 0; i < sclm_pkg::WORD_CHARS; i++) begin
            if (sclm_pkg::POS_W'(i) < i_len) begin
                w_ok[i] = (i_word[i*sclm_pkg::BYTE_W +: sclm_pkg::BYTE_W] ==
                           i_line[i*sclm_pkg::BYTE_W +: sclm_pkg::BYTE_W]);
            end else if (sclm_pkg::POS_W'(i) == i_len) begin
                w_ok[i] = (i_word[i*sclm_pkg::BYTE_W +: sclm_pkg::BYTE_W] == '0);
            end else begin
                w_ok[i] = 1'b1;
            end
        end
    end

    assign o_hit = &w_ok;

endmodule

// ----- src/serial_command_line_matcher_core.sv -----
// a terminator passes the input register, then its result is registered at the output
// throughput: one byte per cycle; only a terminator waiting on a held result stalls
// the line buffer update and the slot compares sit between the input and result registers
// reset (synchronous, active low) empties the line, drops pending requests,
// sets the terminator to carriage return and disables all command slots
module serial_command_line_matcher_core #(
    parameter int LINE_CAP  = 8,
    parameter int CMD_SLOTS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [7:0]                          i_s_axis_tdata,  // [7:0] rx_byte
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [7:0]                          o_m_axis_tdata,  // [0] matched,
                                                // [2:1] command_index, [6:3] line_length
    input  logic                                i_cfg_we,
    input  logic [sclm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sclm_pkg::WORD_W-1:0]         i_cfg_data
);

    logic [sclm_pkg::BYTE_W-1:0]  r_term;
    logic [sclm_pkg::COUNT_W-1:0] r_count;
    logic [sclm_pkg::WORD_W-1:0]  r_words [CMD_SLOTS];

    logic                         r_in_valid;
    logic [sclm_pkg::BYTE_W-1:0]  r_in_byte;

    logic                         r_out_valid;
    logic                         r_out_hit;
    logic [sclm_pkg::SLOT_W-1:0]  r_out_idx;
    logic [sclm_pkg::POS_W-1:0]   r_out_len;

    logic                         w_is_term;
    logic                         w_printable;
    logic                         w_out_free;
    logic                         w_advance;
    sclm_pkg::t_line_ctl          w_ctl;
    logic [sclm_pkg::WORD_W-1:0]  w_line;
    logic [sclm_pkg::POS_W-1:0]   w_pos;
    logic [CMD_SLOTS-1:0]         w_slot_hit;
    logic                         n_hit;
    logic [sclm_pkg::SLOT_W-1:0]  n_idx;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term  <= sclm_pkg::TERM_RESET;
            r_count <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == sclm_pkg::REG_TERMINATOR) begin
                r_term <= i_cfg_data[sclm_pkg::BYTE_W-1:0];
            end
            if (i_cfg_index == sclm_pkg::REG_CMD_COUNT) begin
                r_count <= i_cfg_data[sclm_pkg::COUNT_W-1:0];
            end
        end
    end

    genvar s;
    generate
        for (s = 0; s < CMD_SLOTS; s++) begin : g_slot
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_words[s] <= '0;
                end else if (i_cfg_we &&
                             i_cfg_index == sclm_pkg::REG_WORD0 + sclm_pkg::CFG_IDX_W'(s)) begin
                    r_words[s] <= i_cfg_data;
                end
            end

            sclm_match u_match (
                .i_word (r_words[s]),
                .i_line (w_line),
                .i_len  (w_pos),
                .o_hit  (w_slot_hit[s])
            );
        end
    endgenerate

    // handshake: the input register drains unless a terminator meets a held result
    assign w_is_term  = (r_in_byte == r_term);
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_advance  = r_in_valid && (!w_is_term || w_out_free);
    assign o_s_axis_tready = !r_in_valid || w_advance;

    always_comb begin
        w_printable = 1'b0;
        if (r_in_byte inside {[sclm_pkg::PRINT_LO:sclm_pkg::PRINT_HI]}) begin
            w_printable = 1'b1;
        end
    end

    assign w_ctl.push    = w_advance && !w_is_term && w_printable;
    assign w_ctl.clear   = w_advance && w_is_term;
    assign w_ctl.char_in = r_in_byte;

    sclm_line #(
        .LINE_CAP (LINE_CAP)
    ) u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_line  (w_line),
        .o_pos   (w_pos)
    );

    // lowest enabled slot wins
    always_comb begin
        n_hit = 1'b0;
        n_idx = '0;
        for (int k = CMD_SLOTS - 1; k >= 0; k--) begin
            if (w_slot_hit[k] && (sclm_pkg::COUNT_W'(k) < r_count)) begin
                n_hit = 1'b1;
                n_idx = sclm_pkg::SLOT_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.clear) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.clear) begin
            r_out_hit <= n_hit;
            r_out_idx <= n_idx;
            r_out_len <= w_pos;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_len, r_out_idx, r_out_hit};

    a_blocked_term_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_is_term && !w_out_free) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("blocked terminator lost from input register");

    a_idx_zero_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_hit) |-> (r_out_idx == '0))
        else $error("slot index set without a match");

    a_len_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_len <= sclm_pkg::POS_W'(LINE_CAP)))
        else $error("result line length beyond capacity");

    a_result_from_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_axis_tvalid || i_m_axis_tready) && !w_ctl.clear |=> !o_m_axis_tvalid)
        else $error("result appeared without a terminator");

endmodule

// ----- verif/serial_command_line_matcher_core_tb.sv -----
module serial_command_line_matcher_core_tb;

    localparam int LINE_CAP        = 8;
    localparam int CMD_SLOTS       = 4;
    localparam int DRAIN_SLACK     = 4;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int REPORT_MAX      = 10;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int HOLD_CYCLES     = 400;

    // indexes past the last word register, writes there must be dropped
    localparam logic [sclm_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = sclm_pkg::REG_WORD0 + 3'd4;
    localparam logic [sclm_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = sclm_pkg::REG_WORD0 + 3'd5;

    // enabled slot count per phase, phase 0 in the low bits
    localparam logic [3*N_PHASES-1:0] PHASE_COUNTS =
        {3'd1, 3'd2, 3'd5, 3'd4, 3'd0, 3'd3, 3'd7, 3'd4};

    typedef struct packed {
        logic       pad;
        logic [3:0] length;
        logic [1:0] slot;
        logic       hit;
    } t_line_result;

    typedef enum logic {ROW_BYTE, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind                      kind;
        logic [sclm_pkg::CFG_IDX_W-1:0] idx;
        logic [sclm_pkg::WORD_W-1:0]    value;
        bit                             typed;
        t_line_result                   want;
    } t_stim_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_s_axis_tvalid;
    logic                           o_s_axis_tready;
    logic [7:0]                     i_s_axis_tdata;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready;
    logic [7:0]                     o_m_axis_tdata;
    logic                           i_cfg_we;
    logic [sclm_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [sclm_pkg::WORD_W-1:0]    i_cfg_data;

    // mirror of the block state
    logic [sclm_pkg::BYTE_W-1:0]  term_char;
    logic [sclm_pkg::COUNT_W-1:0] slot_count;
    logic [sclm_pkg::WORD_W-1:0]  slot_word [CMD_SLOTS];
    logic [sclm_pkg::BYTE_W-1:0]  line_buf [LINE_CAP];
    int unsigned                  line_pos;

    t_line_result pending_matches[$];
    t_stim_row    directed_rows[$];
    bit           typed_armed = 1'b0;
    t_line_result typed_result;

    int err_count   = 0;
    int cycle_count = 0;
    int live_items  = 0;
    int sink_hold   = 0;
    bit idle_on     = 1'b1;
    logic [sclm_pkg::BYTE_W-1:0] phase_term;
    logic [sclm_pkg::WORD_W-1:0] phase_word [CMD_SLOTS];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    serial_command_line_matcher_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    function automatic void flag_mismatch(string what);
        err_count++;
        if (err_count <= REPORT_MAX) $display("%0t: %s", $time, what);
    endfunction

    function automatic t_line_result outcome(bit hit, int slot, int len);
        t_line_result r;
        r = '0;
        r.hit = hit;
        r.slot = slot[1:0];
        r.length = len[3:0];
        return r;
    endfunction

    function automatic bit word_equals_line(logic [sclm_pkg::WORD_W-1:0] w, int unsigned len);
        for (int i = 0; i < len; i++)
            if (w[8*i +: 8] != line_buf[i]) return 1'b0;
        // shorter line: the word text must stop right here
        if (len < sclm_pkg::WORD_CHARS && w[8*len +: 8] != 8'h00) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit take_byte(logic [sclm_pkg::BYTE_W-1:0] b, output t_line_result r);
        int unsigned enabled;
        r = '0;
        if (b == term_char) begin
            enabled = (slot_count > CMD_SLOTS) ? CMD_SLOTS : slot_count;
            r.length = line_pos[3:0];
            for (int s = 0; s < enabled; s++) begin
                if (!r.hit && word_equals_line(slot_word[s], line_pos)) begin
                    r.hit = 1'b1;
                    r.slot = s[1:0];
                end
            end
            line_pos = 0;
            return 1'b1;
        end
        if (b >= sclm_pkg::PRINT_LO && b <= sclm_pkg::PRINT_HI) begin
            if (line_pos >= LINE_CAP) line_pos = 0;
            line_buf[line_pos] = b;
            line_pos++;
        end
        return 1'b0;
    endfunction

    function automatic void apply_reg(logic [sclm_pkg::CFG_IDX_W-1:0] idx,
                                      logic [sclm_pkg::WORD_W-1:0] v);
        case (idx)
            sclm_pkg::REG_TERMINATOR: term_char = v[sclm_pkg::BYTE_W-1:0];
            sclm_pkg::REG_CMD_COUNT: slot_count = v[sclm_pkg::COUNT_W-1:0];
            REG_SPARE_LO, REG_SPARE_HI: ;
            default: slot_word[idx - sclm_pkg::REG_WORD0] = v;
        endcase
    endfunction

    function automatic void add_row(t_row_kind kind, logic [sclm_pkg::CFG_IDX_W-1:0] idx,
                                    logic [sclm_pkg::WORD_W-1:0] value, bit typed = 1'b0,
                                    t_line_result want = '0);
        t_stim_row r;
        r.kind = kind;
        r.idx = idx;
        r.value = value;
        r.typed = typed;
        r.want = want;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_byte(logic [sclm_pkg::BYTE_W-1:0] b, bit typed = 1'b0,
                                     t_line_result want = '0);
        add_row(ROW_BYTE, '0, sclm_pkg::WORD_W'(b), typed, want);
    endfunction

    function automatic logic [sclm_pkg::WORD_W-1:0] random_text(
            logic [sclm_pkg::BYTE_W-1:0] avoid);
        logic [sclm_pkg::WORD_W-1:0] w;
        logic [sclm_pkg::BYTE_W-1:0] c;
        int n;
        w = '0;
        n = $urandom_range(0, sclm_pkg::WORD_CHARS);
        for (int i = 0; i < n; i++) begin
            c = sclm_pkg::BYTE_W'($urandom_range(sclm_pkg::PRINT_LO, sclm_pkg::PRINT_HI));
            while (c == avoid)
                c = sclm_pkg::BYTE_W'($urandom_range(sclm_pkg::PRINT_LO, sclm_pkg::PRINT_HI));
            w[8*i +: 8] = c;
        end
        return w;
    endfunction

    // predict on every accepted request and mirror register writes
    always @(posedge i_clk) begin
        t_line_result r;
        if (!i_rst_n) begin
            term_char = sclm_pkg::TERM_RESET;
            slot_count = '0;
            foreach (slot_word[s]) slot_word[s] = '0;
            line_pos = 0;
        end else begin
            if (i_cfg_we) apply_reg(i_cfg_index, i_cfg_data);
            if (i_s_axis_tvalid && o_s_axis_tready && take_byte(i_s_axis_tdata, r))
                pending_matches.push_back(typed_armed ? typed_result : r);
        end
    end

    always @(posedge i_clk) begin
        t_line_result got;
        t_line_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_line_result'(o_m_axis_tdata);
            if (pending_matches.size() == 0) begin
                flag_mismatch($sformatf("unexpected result tdata=%02h", o_m_axis_tdata));
            end else begin
                want = pending_matches.pop_front();
                if (got.hit !== want.hit || got.slot !== want.slot ||
                    got.length !== want.length || got.pad !== 1'b0)
                    flag_mismatch($sformatf({"result mismatch: expected matched=%0d ",
                        "slot=%0d length=%0d, got matched=%0d slot=%0d length=%0d pad=%0d"},
                        want.hit, want.slot, want.length,
                        got.hit, got.slot, got.length, got.pad));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold on request
    initial begin
        i_m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0) begin
                i_m_axis_tready = 1'b0;
                repeat (sink_hold - 1) @(negedge i_clk);
                sink_hold = 0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
            end else begin
                i_m_axis_tready = 1'b1;
            end
        end
    end

    task automatic send_byte(logic [sclm_pkg::BYTE_W-1:0] b);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata = b;
        forever begin
            @(posedge i_clk);
            if (o_s_axis_tready) break;
        end
        @(negedge i_clk);
        if (b == phase_term || (b >= sclm_pkg::PRINT_LO && b <= sclm_pkg::PRINT_HI))
            live_items++;
    endtask

    task automatic write_reg(logic [sclm_pkg::CFG_IDX_W-1:0] idx,
                             logic [sclm_pkg::WORD_W-1:0] v);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        i_s_axis_tvalid = 1'b0;
        while (pending_matches.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        // bytes with no result may still be in the pipe
        repeat (DRAIN_SLACK) @(negedge i_clk);
    endtask

    // one command line: mostly a slot word, sometimes damaged, overlong or noise
    task automatic send_line(logic [sclm_pkg::WORD_W-1:0] w);
        int kind;
        int n;
        logic [sclm_pkg::BYTE_W-1:0] c;
        kind = $urandom_range(0, 99);
        if (kind >= 87) begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(sclm_pkg::BYTE_W'($urandom_range(0, 255)));
        end else if (kind >= 75) begin
            n = $urandom_range(0, 12);
            repeat (n)
                send_byte(sclm_pkg::BYTE_W'($urandom_range(sclm_pkg::PRINT_LO,
                                                           sclm_pkg::PRINT_HI)));
            send_byte(phase_term);
        end else begin
            if (kind >= 65) begin
                n = $urandom_range(0, sclm_pkg::WORD_CHARS - 1);
                w[8*n +: 8] = sclm_pkg::BYTE_W'($urandom_range(sclm_pkg::PRINT_LO,
                                                                sclm_pkg::PRINT_HI));
            end
            for (int i = 0; i < sclm_pkg::WORD_CHARS; i++) begin
                c = w[8*i +: 8];
                if (c == 8'h00) break;
                if (kind >= 55 && kind < 65 && $urandom_range(0, 2) == 0) begin
                    n = $urandom_range(0, 255);
                    while ((n >= sclm_pkg::PRINT_LO && n <= sclm_pkg::PRINT_HI) ||
                           n == phase_term)
                        n = $urandom_range(0, 255);
                    send_byte(n[sclm_pkg::BYTE_W-1:0]);
                end
                send_byte(c);
            end
            send_byte(phase_term);
        end
    endtask

    initial begin
        bit paused;
        paused = 1'b0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        phase_term = sclm_pkg::TERM_RESET;

        // empty line before any slot is enabled
        add_byte(sclm_pkg::TERM_RESET, 1'b1, outcome(1'b0, 0, 0));
        add_row(ROW_REG, sclm_pkg::REG_CMD_COUNT, 64'd4);
        add_row(ROW_REG, sclm_pkg::REG_WORD0, 64'h0000_0000_504C_4548);        // HELP
        add_row(ROW_REG, sclm_pkg::REG_WORD0 + 3'd1, 64'h0);                    // empty word
        add_row(ROW_REG, sclm_pkg::REG_WORD0 + 3'd2, 64'h4847_4645_4443_4241); // full eight chars
        add_row(ROW_REG, sclm_pkg::REG_WORD0 + 3'd3, 64'h0000_0000_0000_7E20); // printable extremes
        add_row(ROW_REG, REG_SPARE_LO, '1);
        add_row(ROW_REG, REG_SPARE_HI, '1);
        add_row(ROW_REG, sclm_pkg::REG_TERMINATOR, sclm_pkg::WORD_W'(sclm_pkg::TERM_RESET));
        add_byte(8'h48);
        add_byte(8'h45);
        add_byte(8'h4C);
        add_byte(8'h50);
        add_byte(sclm_pkg::TERM_RESET, 1'b1, outcome(1'b1, 0, 4));
        // empty line hits the empty word
        add_byte(sclm_pkg::TERM_RESET, 1'b1, outcome(1'b1, 1, 0));
        for (int i = 0; i < sclm_pkg::WORD_CHARS; i++)
            add_byte(sclm_pkg::BYTE_W'(8'h41 + i));
        add_byte(sclm_pkg::TERM_RESET, 1'b1, outcome(1'b1, 2, 8));
        // non-printable bytes are dropped
        add_byte(8'h00);
        add_byte(8'h1F);
        add_byte(8'h7F);
        add_byte(8'hFF);
        add_byte(sclm_pkg::PRINT_LO);
        add_byte(sclm_pkg::PRINT_HI);
        add_byte(sclm_pkg::TERM_RESET, 1'b1, outcome(1'b1, 3, 2));
        add_byte(8'h49);
        add_byte(sclm_pkg::TERM_RESET);

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_REG) begin
                wait_drained();
                write_reg(directed_rows[k].idx, directed_rows[k].value);
            end else begin
                typed_armed = directed_rows[k].typed;
                typed_result = directed_rows[k].want;
                send_byte(directed_rows[k].value[sclm_pkg::BYTE_W-1:0]);
                typed_armed = 1'b0;
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            wait_drained();
            idle_on = !(p == 4 || p == N_PHASES - 1);
            case (p)
                0: phase_term = sclm_pkg::TERM_RESET;
                1: phase_term = 8'h00;
                2: phase_term = 8'hFF;
                3: phase_term = sclm_pkg::BYTE_W'($urandom_range(sclm_pkg::PRINT_LO,
                                                                 sclm_pkg::PRINT_HI));
                default: phase_term = sclm_pkg::BYTE_W'($urandom_range(0, 255));
            endcase
            write_reg(sclm_pkg::REG_TERMINATOR, sclm_pkg::WORD_W'(phase_term));
            write_reg(sclm_pkg::REG_CMD_COUNT, sclm_pkg::WORD_W'(PHASE_COUNTS[3*p +: 3]));
            foreach (phase_word[s]) phase_word[s] = random_text(phase_term);
            // duplicate slot: the lower one must win
            if (p == 2) phase_word[2] = phase_word[1];
            if (p == 6) begin
                phase_word[0] = '1;
                phase_word[1] = {$urandom, $urandom};
            end
            for (int s = 0; s < CMD_SLOTS; s++)
                write_reg(sclm_pkg::REG_WORD0 + 3'(s), phase_word[s]);
            // long result-side hold while requests keep coming
            if (p == 3) sink_hold = HOLD_CYCLES;
            live_items = 0;
            while (live_items < ITEMS_PER_PHASE) begin
                if (p == 5 && !paused && live_items >= ITEMS_PER_PHASE / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
                send_line(phase_word[$urandom_range(0, CMD_SLOTS - 1)]);
            end
        end

        wait_drained();
        if (pending_matches.size() != 0)
            flag_mismatch($sformatf("%0d expected results never arrived",
                                    pending_matches.size()));
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- serial_command_line_matcher_core.f -----
src/sclm_pkg.sv
src/sclm_line.sv
src/sclm_match.sv
src/serial_command_line_matcher_core.sv
verif/serial_command_line_matcher_core_tb.sv
